// ----- hdl/scsc_pkg.sv -----
// Shared types, constants and codes for the sparse CSR structure checker.
// No dependencies; every other file but scsc_checker.sv imports this package.
package scsc_pkg;

  localparam int MAX_ROWS     = 4096;
  localparam int MAX_NONZEROS = 65536;

  localparam int ROW_W  = 13;  // row counts and pointer-store index
  localparam int NZ_W   = 17;  // nonzero counts and pointer values
  localparam int COL_W  = 17;  // column counts
  localparam int DF_AW  = 12;  // diagonal-found store index
  localparam int DF_W   = 16;  // diagonal-found entry
  localparam int IDX_W  = 2;   // configuration register index

  localparam logic [1:0] OP_POINTER = 2'd0;
  localparam logic [1:0] OP_INDEX   = 2'd1;
  localparam logic [1:0] OP_DIAG    = 2'd2;
  localparam logic [1:0] OP_VALUE   = 2'd3;

  localparam logic [IDX_W-1:0] REG_EXTENDED  = 2'd0;
  localparam logic [IDX_W-1:0] REG_NUM_ROWS  = 2'd1;
  localparam logic [IDX_W-1:0] REG_NUM_COLS  = 2'd2;
  localparam logic [IDX_W-1:0] REG_NUM_NZ    = 2'd3;

  localparam logic [1:0] STATUS_VALID   = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_ZERO    = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] entry_value;
    logic               last_item;
  } item_t;

  typedef struct packed {
    logic             extended_mode;
    logic [ROW_W-1:0] num_rows;
    logic [COL_W-1:0] num_cols;
    logic [NZ_W-1:0]  num_nonzeros;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// ----- hdl/scsc_front_queue.sv -----
// Front end of the checker: accepts transactions into a two-entry queue.
// Depends on scsc_pkg for the item and queue-head types.
module scsc_front_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scsc_pkg::item_t      in_item,
  output scsc_pkg::queue_head_t head,
  input  logic                 pop
);
  import scsc_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       do_pop;

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

  // Store incoming transactions
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

endmodule

// ----- hdl/scsc_back_exec.sv -----
// Back end of the checker: applies each queued item to the stream state,
// holds the pointer and diagonal stores, and registers the final status.
// Depends on scsc_pkg.
module scsc_back_exec (
  input  logic                  clk,
  input  logic                  rst,
  input  scsc_pkg::cfg_t        cfg,
  input  scsc_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status
);
  import scsc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_DIAG = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [ROW_W-1:0] MAX_ROWS_C = ROW_W'(MAX_ROWS);
  localparam logic [NZ_W-1:0]  MAX_NZ_C   = NZ_W'(MAX_NONZEROS);
  localparam logic [NZ_W-1:0]  NZ_SAT     = {NZ_W{1'b1}};

  logic [NZ_W-1:0] row_ptr_mem  [MAX_ROWS+1];
  logic [DF_W-1:0] diag_mem     [MAX_ROWS];
  logic [NZ_W-1:0] rp_rdata;
  logic [DF_W-1:0] df_rdata;

  logic [2:0]       state;
  logic [ROW_W-1:0] pointer_count;
  logic [NZ_W-1:0]  index_count;
  logic [NZ_W-1:0]  value_count;
  logic [ROW_W-1:0] diag_count;
  logic [ROW_W-1:0] diag_found_count;
  logic [ROW_W-1:0] current_row;
  logic [COL_W-1:0] previous_column;
  logic [NZ_W-1:0]  last_ptr;
  logic [NZ_W-1:0]  row_begin;
  logic             failed;
  logic signed [31:0] cur_val;
  logic             cur_last;

  logic             out_free;
  logic [ROW_W:0]   rows_plus1;
  logic [COL_W-1:0] diag_expect;
  logic             ptr_fail;
  logic             idx_pre_fail;
  logic             diag_pre_fail;
  logic             go_scan;
  logic             go_diag;
  logic             col_bad;
  logic             ext_fail;
  logic             is_diag;
  logic [NZ_W-1:0]  v17;
  logic [COL_W-1:0] c17;
  logic [1:0]       fin_status;
  logic             rp_we;
  logic             df_we;
  logic             rp_re;
  logic             df_re;

  assign out_free    = !out_valid || out_ready;
  assign rows_plus1  = {1'b0, cfg.num_rows} + {{ROW_W{1'b0}}, 1'b1};
  assign diag_expect = ({4'b0, cfg.num_rows} < cfg.num_cols) ?
                       {4'b0, cfg.num_rows} : cfg.num_cols;
  assign v17 = head.item.entry_value[NZ_W-1:0];
  assign c17 = cur_val[COL_W-1:0];

  // Take the head item in idle; a last item waits for a free output slot
  assign pop = (state == ST_IDLE) && head.valid && (!head.item.last_item || out_free);

  // Pointer checks on the head item
  always_comb begin
    ptr_fail = (index_count != '0) || (diag_count != '0) ||
               (pointer_count > cfg.num_rows) || (pointer_count > MAX_ROWS_C);
    if (head.item.entry_value[31] || (head.item.entry_value[31:NZ_W] != '0) ||
        (v17 > cfg.num_nonzeros)) begin
      ptr_fail = 1'b1;
    end else if (pointer_count == '0) begin
      if (v17 != '0) ptr_fail = 1'b1;
    end else if (cfg.extended_mode ? (v17 <= last_ptr) : (v17 < last_ptr)) begin
      ptr_fail = 1'b1;
    end
  end

  // Ordering and count checks before an index or a diagonal is applied
  assign idx_pre_fail  = (diag_count != '0) || (index_count >= cfg.num_nonzeros) ||
                         ({1'b0, pointer_count} != rows_plus1) ||
                         (cfg.num_rows > MAX_ROWS_C) || (last_ptr != cfg.num_nonzeros);
  assign diag_pre_fail = (index_count != cfg.num_nonzeros) ||
                         ({4'b0, diag_count} >= diag_expect) ||
                         (diag_count >= diag_found_count) || (diag_count >= MAX_ROWS_C);

  // Items that continue in a multi-cycle state
  assign go_scan = pop && !failed && (head.item.op == OP_INDEX) && !idx_pre_fail;
  assign go_diag = pop && !failed && (head.item.op == OP_DIAG) && cfg.extended_mode &&
                   !diag_pre_fail;

  // Column checks once the owning row is known
  always_comb begin
    col_bad  = cur_val[31] || (cur_val[31:COL_W] != '0) || (c17 >= cfg.num_cols);
    is_diag  = (c17 == {4'b0, current_row});
    ext_fail = 1'b0;
    if ((rp_rdata - row_begin == NZ_W'(1)) && !is_diag) ext_fail = 1'b1;
    if ((index_count != row_begin) && (c17 <= previous_column)) ext_fail = 1'b1;
    if (is_diag && (diag_found_count >= MAX_ROWS_C)) ext_fail = 1'b1;
  end

  // Final status from the settled stream state
  always_comb begin
    if ((cfg.num_rows == '0) || (cfg.num_cols == '0) || (cfg.num_nonzeros == '0)) begin
      fin_status = STATUS_ZERO;
    end else if (failed || (cfg.num_rows > MAX_ROWS_C) || (cfg.num_nonzeros > MAX_NZ_C) ||
                 ({1'b0, pointer_count} != rows_plus1) || (last_ptr != cfg.num_nonzeros) ||
                 (index_count != cfg.num_nonzeros) || (value_count != cfg.num_nonzeros) ||
                 (cfg.extended_mode && (({4'b0, diag_count} != diag_expect) ||
                                        (diag_found_count != diag_count)))) begin
      fin_status = STATUS_INVALID;
    end else begin
      fin_status = STATUS_VALID;
    end
  end

  assign rp_we = pop && !failed && (head.item.op == OP_POINTER) && !ptr_fail;
  assign rp_re = (state == ST_SCAN) && (current_row < cfg.num_rows);
  assign df_we = (state == ST_WAIT) && (rp_rdata > index_count) && !failed && !col_bad &&
                 cfg.extended_mode && !ext_fail && is_diag;
  assign df_re = pop && !failed && (head.item.op == OP_DIAG) && cfg.extended_mode;

  // Row pointer store
  always_ff @(posedge clk) begin
    if (rp_we) row_ptr_mem[pointer_count] <= v17;
    if (rp_re) rp_rdata <= row_ptr_mem[current_row + ROW_W'(1)];
  end

  // Diagonal-found store
  always_ff @(posedge clk) begin
    if (df_we) diag_mem[diag_found_count[DF_AW-1:0]] <= index_count[DF_W-1:0];
    if (df_re) df_rdata <= diag_mem[diag_count[DF_AW-1:0]];
  end

  // Item sequencer and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      pointer_count    <= '0;
      index_count      <= '0;
      value_count      <= '0;
      diag_count       <= '0;
      diag_found_count <= '0;
      current_row      <= '0;
      previous_column  <= '0;
      last_ptr         <= '0;
      row_begin        <= '0;
      failed           <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            cur_val  <= head.item.entry_value;
            cur_last <= head.item.last_item;
            if (go_scan) state <= ST_SCAN;
            else if (go_diag) state <= ST_DIAG;
            else if (head.item.last_item) state <= ST_FIN;
            if (head.item.op == OP_VALUE) begin
              if (value_count != NZ_SAT) value_count <= value_count + NZ_W'(1);
            end else if (!failed) begin
              unique case (head.item.op)
                OP_POINTER: begin
                  if (ptr_fail) begin
                    failed <= 1'b1;
                  end else begin
                    last_ptr      <= v17;
                    pointer_count <= pointer_count + ROW_W'(1);
                  end
                end
                OP_INDEX: begin
                  if (idx_pre_fail) failed <= 1'b1;
                end
                OP_DIAG: begin
                  if (cfg.extended_mode && diag_pre_fail) failed <= 1'b1;
                end
                default: ;
              endcase
            end
          end
        end
        ST_SCAN: begin
          if (current_row >= cfg.num_rows) begin
            failed <= 1'b1;
            state  <= cur_last ? ST_FIN : ST_IDLE;
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (rp_rdata <= index_count) begin
            // Row already exhausted: step to the next row
            current_row <= current_row + ROW_W'(1);
            row_begin   <= rp_rdata;
            state       <= ST_SCAN;
          end else begin
            state <= cur_last ? ST_FIN : ST_IDLE;
            if (col_bad || (cfg.extended_mode && ext_fail)) begin
              failed <= 1'b1;
            end else begin
              if (df_we) diag_found_count <= diag_found_count + ROW_W'(1);
              previous_column <= c17;
              index_count     <= index_count + NZ_W'(1);
            end
          end
        end
        ST_DIAG: begin
          state <= cur_last ? ST_FIN : ST_IDLE;
          if (cur_val[31] || (cur_val != {16'b0, df_rdata})) failed <= 1'b1;
          else diag_count <= diag_count + ROW_W'(1);
        end
        ST_FIN: begin
          status           <= fin_status;
          out_valid        <= 1'b1;
          state            <= ST_IDLE;
          pointer_count    <= '0;
          index_count      <= '0;
          value_count      <= '0;
          diag_count       <= '0;
          diag_found_count <= '0;
          current_row      <= '0;
          previous_column  <= '0;
          last_ptr         <= '0;
          row_begin        <= '0;
          failed           <= 1'b0;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/sparse_csr_structure_checker.sv -----
// Top level of the sparse CSR structure checker: configuration registers,
// front queue and back executor. Depends on scsc_pkg, scsc_front_queue, scsc_back_exec.
//
//   channel   direction  signals
//   config    in         write_en, write_index, write_data
//   items     in         in_valid/in_ready: op, entry_value, last_item
//   result    out        out_valid/out_ready: status
//
// Value items and pointers are applied at pop; a column index passes through pop,
// pointer store read (scan) and check (wait); scan and wait repeat per exhausted row.
// A diagonal position is popped with a store read, then checked; a last item adds FIN.
// A last item waits in the queue while an earlier status is still unaccepted.
// The two-entry queue accepts items while the back end works or the status waits.
// Reset clears all stream state and configuration; the stores are not cleared.
module sparse_csr_structure_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       write_en,
  input  logic [scsc_pkg::IDX_W-1:0] write_index,
  input  logic [scsc_pkg::NZ_W-1:0]  write_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 op,
  input  logic signed [31:0]         entry_value,
  input  logic                       last_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status
);
  import scsc_pkg::*;

  cfg_t        cfg;
  item_t       in_item;
  queue_head_t head;
  logic        pop;

  assign in_item.op          = op;
  assign in_item.entry_value = entry_value;
  assign in_item.last_item   = last_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (write_en) begin
      unique case (write_index)
        REG_EXTENDED: cfg.extended_mode <= write_data[0];
        REG_NUM_ROWS: cfg.num_rows      <= write_data[ROW_W-1:0];
        REG_NUM_COLS: cfg.num_cols      <= write_data[COL_W-1:0];
        REG_NUM_NZ:   cfg.num_nonzeros  <= write_data[NZ_W-1:0];
        default: ;
      endcase
    end
  end

  scsc_front_queue u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  scsc_back_exec u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status)
  );

endmodule

// ----- hdl/scsc_checker.sv -----
// Port-level checks for the sparse CSR structure checker, bound to the top.
// Depends only on the top level's ports.
module scsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status
);

  // Drop any pending result on reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("stalled result changed");

  // Never emit an undefined status code
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

endmodule

bind sparse_csr_structure_checker scsc_checker u_scsc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status)
);

// ----- sim/sparse_csr_structure_checker_tb.sv -----
// Testbench for the sparse CSR structure checker: matrix streams, status checks.
// Depends on scsc_pkg and the sparse_csr_structure_checker top level.
module sparse_csr_structure_checker_tb;
  import scsc_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;
  logic write_en;
  logic [IDX_W-1:0] write_index;
  logic [NZ_W-1:0] write_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] op;
  logic signed [31:0] entry_value;
  logic last_item;
  logic out_valid;
  logic out_ready;
  logic [1:0] status;

  sparse_csr_structure_checker dut (
    .clk(clk), .rst(rst), .write_en(write_en), .write_index(write_index),
    .write_data(write_data), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .entry_value(entry_value), .last_item(last_item), .out_valid(out_valid),
    .out_ready(out_ready), .status(status)
  );

  // Configuration copy and stream state of the checker model
  logic m_ext;
  int unsigned m_rows, m_cols, m_nz;
  int unsigned ptr_mem [0:MAX_ROWS];
  int unsigned diag_mem [0:MAX_ROWS-1];
  int unsigned n_ptr, n_idx, n_val, n_diag, n_found, cur_row;
  longint prev_col;
  bit broken;

  item_t pending_items [$];
  logic [1:0] expected_status [$];
  int errors;
  bit idle_on;
  bit hold_long;
  bit hold_start;
  int hold_cnt;
  int send_gap, recv_gap, quiet_cycles;
  bit stim_done;

  function automatic int unsigned min_dim();
    return (m_rows < m_cols) ? m_rows : m_cols;
  endfunction

  function automatic void clear_stream();
    n_ptr = 0; n_idx = 0; n_val = 0; n_diag = 0; n_found = 0;
    cur_row = 0; prev_col = 0; broken = 0;
  endfunction

  function automatic void take_pointer(longint v);
    int unsigned p;
    p = n_ptr;
    if (n_idx != 0 || n_diag != 0 || p >= m_rows + 1 || p > MAX_ROWS) begin
      broken = 1; return;
    end
    if (v < 0 || v > longint'(m_nz)) begin broken = 1; return; end
    if (p == 0) begin
      if (v != 0) begin broken = 1; return; end
    end else if (m_ext ? (v <= longint'(ptr_mem[p-1])) : (v < longint'(ptr_mem[p-1]))) begin
      broken = 1; return;
    end
    ptr_mem[p] = int'(v);
    n_ptr = p + 1;
  endfunction

  function automatic void take_column(longint c);
    int unsigned k, r, b, e;
    k = n_idx;
    if (n_diag != 0 || k >= m_nz || n_ptr != m_rows + 1 || m_rows > MAX_ROWS
        || ptr_mem[m_rows] != m_nz) begin
      broken = 1; return;
    end
    while (cur_row < m_rows && ptr_mem[cur_row+1] <= k) cur_row++;
    if (cur_row >= m_rows) begin broken = 1; return; end
    r = cur_row; b = ptr_mem[r]; e = ptr_mem[r+1];
    if (c < 0 || c >= longint'(m_cols)) begin broken = 1; return; end
    if (m_ext) begin
      if (e - b == 1 && c != longint'(r)) begin broken = 1; return; end
      if (k != b && c <= prev_col) begin broken = 1; return; end
      if (c == longint'(r)) begin
        if (n_found >= MAX_ROWS) begin broken = 1; return; end
        diag_mem[n_found] = k;
        n_found++;
      end
    end
    prev_col = c;
    n_idx = k + 1;
  endfunction

  function automatic void take_diag(longint v);
    int unsigned d;
    d = n_diag;
    if (!m_ext) return;
    if (n_idx != m_nz || d >= min_dim() || d >= n_found || d >= MAX_ROWS) begin
      broken = 1; return;
    end
    if (v < 0 || v != longint'(diag_mem[d])) begin broken = 1; return; end
    n_diag = d + 1;
  endfunction

  function automatic logic [1:0] matrix_status();
    if (m_rows == 0 || m_cols == 0 || m_nz == 0) return STATUS_ZERO;
    if (broken || m_rows > MAX_ROWS || m_nz > MAX_NONZEROS) return STATUS_INVALID;
    if (n_ptr != m_rows + 1 || ptr_mem[m_rows] != m_nz) return STATUS_INVALID;
    if (n_idx != m_nz || n_val != m_nz) return STATUS_INVALID;
    if (m_ext && (n_diag != min_dim() || n_found != n_diag)) return STATUS_INVALID;
    return STATUS_VALID;
  endfunction

  // Advance the model by one accepted transaction
  function automatic void predict_item(item_t it);
    if (it.op == OP_VALUE) begin
      if (n_val < 17'h1FFFF) n_val++;
    end else if (!broken) begin
      case (it.op)
        OP_POINTER: take_pointer(longint'(it.entry_value));
        OP_INDEX: take_column(longint'(it.entry_value));
        default: take_diag(longint'(it.entry_value));
      endcase
    end
    if (it.last_item) begin
      expected_status.push_back(matrix_status());
      clear_stream();
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: offer queued items, with random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) predict_item(item_t'{op, entry_value, last_item});
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          in_valid <= 0;
          send_gap <= send_gap - 1;
        end else if (pending_items.size() > 0) begin
          if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 0;
            send_gap <= $urandom_range(1, 16) - 1;
          end else begin
            item_t it;
            it = pending_items.pop_front();
            in_valid <= 1;
            op <= it.op;
            entry_value <= it.entry_value;
            last_item <= it.last_item;
          end
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here in cycles
  always @(posedge clk) begin
    if (rst) hold_cnt <= 0;
    else if (hold_start) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  assign hold_long = (hold_cnt != 0);

  // Monitor: check statuses and drive out_ready with stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      recv_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) report_mismatch($sformatf("unexpected status %0d", status));
        else begin
          logic [1:0] want;
          want = expected_status.pop_front();
          if (status !== want) report_mismatch($sformatf("status %0d, expected %0d", status, want));
        end
      end
      if (hold_long) out_ready <= 0;
      else if (recv_gap > 0) begin
        out_ready <= 0;
        recv_gap <= recv_gap - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        recv_gap <= $urandom_range(1, 16) - 1;
      end else out_ready <= 1;
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || hold_long)
      quiet_cycles <= 0;
    else if (!stim_done) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_item(logic [1:0] o, logic signed [31:0] v, logic l);
    pending_items.push_back(item_t'{o, v, l});
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [NZ_W-1:0] val);
    @(posedge clk);
    write_en <= 1; write_index <= idx; write_data <= val;
    @(posedge clk);
    write_en <= 0;
    case (idx)
      REG_EXTENDED: m_ext = val[0];
      REG_NUM_ROWS: m_rows = val[ROW_W-1:0];
      REG_NUM_COLS: m_cols = val[COL_W-1:0];
      default: m_nz = val;
    endcase
  endtask

  task automatic set_config(logic x, int r, int c, int n);
    write_reg(REG_EXTENDED, NZ_W'(x));
    write_reg(REG_NUM_ROWS, NZ_W'(r));
    write_reg(REG_NUM_COLS, NZ_W'(c));
    write_reg(REG_NUM_NZ, NZ_W'(n));
  endtask

  // Wait for every queued item and status, then let the back end drain
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_status.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Queue one well-formed matrix of the configured shape, sometimes corrupted
  task automatic push_matrix(int corrupt);
    int cnt [];
    int ptr;
    int k;
    int cols_in_row [$];
    int r;
    int c;
    int nvals;
    int bad;
    int diags [$];
    item_t stream [$];
    cnt = new[m_rows];
    foreach (cnt[i]) cnt[i] = m_ext ? 1 : 0;
    for (k = (m_ext ? m_rows : 0); k < m_nz; k++) cnt[$urandom_range(0, m_rows-1)]++;
    ptr = 0;
    stream.push_back(item_t'{OP_POINTER, 32'sd0, 1'b0});
    for (r = 0; r < m_rows; r++) begin
      ptr += cnt[r];
      stream.push_back(item_t'{OP_POINTER, ptr, 1'b0});
    end
    k = 0;
    for (r = 0; r < m_rows; r++) begin
      cols_in_row.delete();
      if (cnt[r] == 1 && m_ext) cols_in_row.push_back(r < m_cols ? r : 0);
      else begin
        c = m_ext ? $urandom_range(0, 2) : 0;
        for (int j = 0; j < cnt[r]; j++) begin
          if (m_ext) begin
            if (j > 0) c += $urandom_range(1, 2);
            if ($urandom_range(0, 1) && r >= c && r < m_cols) c = r;
            cols_in_row.push_back(c);
          end else cols_in_row.push_back($urandom_range(0, m_cols-1));
        end
      end
      foreach (cols_in_row[j]) begin
        if (m_ext && cols_in_row[j] == r) diags.push_back(k);
        stream.push_back(item_t'{OP_INDEX, cols_in_row[j], 1'b0});
        k++;
      end
    end
    if (m_ext) foreach (diags[j]) stream.push_back(item_t'{OP_DIAG, diags[j], 1'b0});
    nvals = m_nz;
    for (int j = 0; j < nvals; j++)
      stream.insert($urandom_range(0, stream.size()), item_t'{OP_VALUE, $urandom, 1'b0});
    if (corrupt) begin
      bad = $urandom_range(0, stream.size()-1);
      case ($urandom_range(0, 3))
        0: stream[bad].entry_value = $urandom;
        1: stream[bad].entry_value = stream[bad].entry_value + 1;
        2: stream.delete(bad);
        default: stream[bad].op = 2'($urandom_range(0, 3));
      endcase
    end
    if (stream.size() == 0) stream.push_back(item_t'{OP_VALUE, 0, 1'b0});
    stream[stream.size()-1].last_item = 1;
    foreach (stream[j]) pending_items.push_back(stream[j]);
  endtask

  initial begin
    int sent;
    int n;
    bit first_round;
    rst = 1; write_en = 0; write_index = 0; write_data = 0;
    in_valid = 0; op = 0; entry_value = 0; last_item = 0; out_ready = 0;
    errors = 0; idle_on = 1; hold_start = 0; stim_done = 0;
    m_ext = 0; m_rows = 0; m_cols = 0; m_nz = 0;
    clear_stream();
    repeat (5) @(posedge clk);
    rst <= 0;

    // Directed: zero sizes at reset, then every op and field extreme
    push_item(OP_POINTER, 32'sh7FFFFFFF, 1'b1);
    drain();
    set_config(1, 1, 1, 1);
    push_item(OP_POINTER, 0, 0); push_item(OP_POINTER, 1, 0);
    push_item(OP_INDEX, 0, 0); push_item(OP_VALUE, 32'sh80000000, 0);
    push_item(OP_DIAG, 0, 1);
    push_item(OP_POINTER, 32'sh80000000, 0); push_item(OP_INDEX, -1, 1);
    push_item(OP_POINTER, 5, 1);
    push_item(OP_INDEX, 0, 0); push_item(OP_DIAG, 32'sh7FFFFFFF, 1);
    drain();
    set_config(0, 2, 3, 2);
    push_item(OP_POINTER, 0, 0); push_item(OP_POINTER, 0, 0);
    push_item(OP_POINTER, 2, 0); push_item(OP_INDEX, 2, 0);
    push_item(OP_INDEX, 3, 0); push_item(OP_DIAG, 1, 0);
    push_item(OP_VALUE, 0, 0); push_item(OP_VALUE, -1, 1);
    drain();
    set_config(0, 4097, 1, 65537);
    push_item(OP_POINTER, 0, 1);
    drain();
    set_config(1, 16, 65536, 24);
    push_matrix(0);
    drain();

    // Random matrices; a long receiver hold-off in the first round
    sent = 0;
    first_round = 1;
    while (sent < 650) begin
      set_config($urandom_range(0, 1), $urandom_range(1, 8), $urandom_range(1, 10),
                 $urandom_range(0, 20));
      if (m_ext && m_nz < m_rows) m_nz = m_rows;
      write_reg(REG_NUM_NZ, NZ_W'(m_nz));
      if (m_ext && m_cols < m_rows) write_reg(REG_NUM_COLS, NZ_W'(m_rows));
      if (sent > 500) idle_on = 0;
      n = $urandom_range(2, 5);
      for (int j = 0; j < n; j++) begin
        if (m_nz == 0 || $urandom_range(0, 7) == 0) begin
          push_item(2'($urandom_range(0, 3)), $urandom, 0);
          push_item(2'($urandom_range(0, 3)), $urandom, 1);
        end else push_matrix($urandom_range(0, 3) == 0);
      end
      sent += pending_items.size();
      if (first_round) begin
        first_round = 0;
        @(posedge clk);
        hold_start <= 1;
        @(posedge clk);
        hold_start <= 0;
      end
      drain();
    end
    stim_done = 1;
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- sparse_csr_structure_checker.f -----
hdl/scsc_pkg.sv
hdl/scsc_front_queue.sv
hdl/scsc_back_exec.sv
hdl/sparse_csr_structure_checker.sv
hdl/scsc_checker.sv
sim/sparse_csr_structure_checker_tb.sv
